@@ rtl/core/pmfa_pkg.sv @@
// pmfa_pkg: shared constants and types for the particulate sensor frame averager
// no dependencies; imported by the parser, the serial divider and the top level

package pmfa_pkg;

    // request kinds carried in s_tuser
    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_BYTE    = 2'd1;
    localparam logic [1:0] REQ_COLLECT = 2'd2;

    // run command codes reported with every result
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_READING  = 2'd2;

    localparam logic [31:0] INTERVAL_RESET = 32'd145000;
    localparam logic [15:0] WARMUP_RESET   = 16'd15000;
    localparam logic [15:0] READING_RESET  = 16'd5000;

    // sensor frame bytes
    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'hC0;
    localparam logic [7:0] TAIL_BYTE  = 8'hAB;

    localparam logic [15:0] MIN_RESET = 16'd20000;
    localparam logic [15:0] SAT_16    = 16'hFFFF;

    // sum*10 needs 36 bits, the reported mean keeps the low 20
    localparam int DIV_W = 36;
    localparam int AVG_W = 20;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 96;
    localparam int M_USER_W = 4;

    typedef struct packed {
        logic        done;
        logic        ok;
        logic [15:0] pm25;
        logic [15:0] pm10;
    } frame_t;

endpackage

@@ rtl/core/pmfa_frame_parser.sv @@
// pmfa_frame_parser: byte-wise parser for the sensor reply frame (header, body, checksum, tail)
// depends on pmfa_pkg for frame constants and the frame_t result type

module pmfa_frame_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             restart,
    input  logic             byte_en,
    input  logic [7:0]       byte_in,
    output pmfa_pkg::frame_t frame
);
    import pmfa_pkg::*;

    localparam logic [3:0] PH_WAIT_HDR = 4'd0;
    localparam logic [3:0] PH_GOT_HDR  = 4'd1;
    localparam logic [3:0] PH_BODY0    = 4'd2;
    localparam logic [3:0] PH_BODY4    = 4'd6;
    localparam logic [3:0] PH_CHECK    = 4'd8;

    logic [3:0] phase_reg, phase_next, phase_cur;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] body_reg [4];
    logic [7:0] check_reg;
    logic [3:0] body_idx;

    assign phase_cur = restart ? PH_WAIT_HDR : phase_reg;
    assign body_idx  = phase_cur - PH_BODY0;

    always_comb begin
        phase_next = phase_cur;
        sum_next   = sum_reg;
        frame      = '0;
        if (byte_en) begin
            priority if (phase_cur == PH_WAIT_HDR) begin
                phase_next = (byte_in == HDR_FIRST) ? PH_GOT_HDR : PH_WAIT_HDR;
            end else if (phase_cur == PH_GOT_HDR) begin
                if (byte_in == HDR_SECOND) begin
                    phase_next = PH_BODY0;
                    sum_next   = '0;
                end else begin
                    // a repeated first header byte keeps the half-found header
                    phase_next = (byte_in == HDR_FIRST) ? PH_GOT_HDR : PH_WAIT_HDR;
                end
            end else if (phase_cur < PH_CHECK) begin
                sum_next   = sum_reg + byte_in;
                phase_next = phase_cur + 4'd1;
            end else if (phase_cur == PH_CHECK) begin
                phase_next = phase_cur + 4'd1;
            end else begin
                frame.done = 1'b1;
                frame.ok   = (byte_in == TAIL_BYTE) && (sum_reg == check_reg);
                frame.pm25 = {body_reg[1], body_reg[0]};
                frame.pm10 = {body_reg[3], body_reg[2]};
                phase_next = PH_WAIT_HDR;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WAIT_HDR;
            sum_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_en && phase_cur >= PH_BODY0 && phase_cur < PH_BODY4) begin
            body_reg[body_idx[1:0]] <= byte_in;
        end
        if (byte_en && phase_cur == PH_CHECK) begin
            check_reg <= byte_in;
        end
    end

endmodule

@@ rtl/core/pmfa_div.sv @@
// pmfa_div: restoring serial divider, one quotient bit per cycle
// depends on pmfa_pkg for the dividend and result widths

module pmfa_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [pmfa_pkg::DIV_W-1:0]   dividend,
    input  logic [15:0]                  divisor,
    output logic                         busy,
    output logic                         done,
    output logic [pmfa_pkg::AVG_W-1:0]   quotient
);
    import pmfa_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

    logic [DIV_W-1:0] dq_reg, dq_next;
    logic [15:0]      rem_reg, rem_next;
    logic [16:0]      shifted, trial;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    // dividend bits leave at the top, quotient bits enter at the bottom
    assign shifted = {rem_reg, dq_reg[DIV_W-1]};
    assign trial   = shifted - {1'b0, divisor};

    always_comb begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dq_next   = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[16]) begin
                rem_next = trial[15:0];
                dq_next  = {dq_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[15:0];
                dq_next  = {dq_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dq_reg[AVG_W-1:0];

endmodule

@@ rtl/core/pm_sensor_frame_averager.sv @@
// pm_sensor_frame_averager: top level, sequencer, sample store and output register
// depends on pmfa_pkg, pmfa_frame_parser and pmfa_div
//
// Usage:
//   s_ channel: one item per handshake; s_tuser carries the request kind (tick, received
//   sensor byte, collect), s_tdata the byte and the time within the send interval.
//   m_ channel: exactly one result item per input item, in order.
//   cfg channel: writes interval, warm-up and reading lengths; always ready. The user must
//   see that it is only written while no item is in flight; the block does not enforce this.
//   Sequencing: a tick or byte passes through the lead, window, execute and output states.
//   A collect with three or more samples trims the minimum and maximum, then runs two
//   divisions (sum*10 over the kept sample count, one for each reading) on the one serial
//   divider; with one or two samples there is no trimming, and an empty store skips the
//   divider. A new item is accepted only once the previous one has left the sequencer.
//   s_tready is high only while the sequencer is idle. A finished result sits in the
//   output register; the next item is accepted while it waits, and that item's result
//   is held in the sequencer until the receiver takes the pending one.
//   Reset: synchronous, active low; restores default lengths, stops the sensor flag,
//   clears the sample store and the error count, and empties the output register.

module pm_sensor_frame_averager (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: rx_byte[7:0], time_ms[39:8]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [pmfa_pkg::S_DATA_W-1:0]    s_tdata,
    // s_tuser: req_type[1:0]
    input  logic [1:0]                       s_tuser,
    // m_tdata: pm25_raw[15:0], pm10_raw[31:16], avg_pm10_deci[51:32],
    //          avg_pm25_deci[71:52], error_total[87:72], sensor_on[88],
    //          run_command[90:89], zero fill[95:91]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pmfa_pkg::M_DATA_W-1:0]    m_tdata,
    // m_tuser: frame_done[0], frame_ok[1], sample_taken[2], avg_valid[3]
    output logic [pmfa_pkg::M_USER_W-1:0]    m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pmfa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_data
);
    import pmfa_pkg::*;

    typedef struct packed {
        logic [4:0]       pad;
        logic [1:0]       cmd;
        logic             sensor_on;
        logic [15:0]      error_total;
        logic [AVG_W-1:0] avg25;
        logic [AVG_W-1:0] avg10;
        logic [15:0]      pm10;
        logic [15:0]      pm25;
    } out_data_t;

    typedef struct packed {
        logic avg_valid;
        logic taken;
        logic ok;
        logic done;
    } out_user_t;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_LEAD     = 4'd1;
    localparam logic [3:0] ST_WIN      = 4'd2;
    localparam logic [3:0] ST_EXEC     = 4'd3;
    localparam logic [3:0] ST_TRIM_MIN = 4'd4;
    localparam logic [3:0] ST_TRIM_MAX = 4'd5;
    localparam logic [3:0] ST_START10  = 4'd6;
    localparam logic [3:0] ST_DIV10    = 4'd7;
    localparam logic [3:0] ST_START25  = 4'd8;
    localparam logic [3:0] ST_DIV25    = 4'd9;
    localparam logic [3:0] ST_FINISH   = 4'd10;
    localparam logic [3:0] ST_OUT      = 4'd11;

    logic [3:0]  state_reg, state_next;

    // configuration
    logic [31:0] interval_reg, interval_next;
    logic [15:0] warmup_reg, warmup_next;
    logic [15:0] reading_reg, reading_next;

    // latched item
    logic [1:0]  req_reg, req_next;
    logic [7:0]  byte_reg, byte_next;
    logic [31:0] time_reg, time_next;

    // window bounds worked out per item
    logic [16:0] lead_reg, lead_next;
    logic        long_iv_reg, long_iv_next;
    logic [31:0] win_start_reg, win_start_next;
    logic [31:0] thr_reg, thr_next;

    // sample store
    logic [31:0] coarse_sum_reg, coarse_sum_next;
    logic [31:0] fine_sum_reg, fine_sum_next;
    logic [15:0] coarse_min_reg, coarse_min_next;
    logic [15:0] coarse_max_reg, coarse_max_next;
    logic [15:0] fine_min_reg, fine_min_next;
    logic [15:0] fine_max_reg, fine_max_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] error_reg, error_next;
    logic        running_reg, running_next;

    // collect working values
    logic [31:0] s10_reg, s10_next;
    logic [31:0] s25_reg, s25_next;
    logic [15:0] n_reg, n_next;

    // result under construction
    logic             res_done_reg, res_done_next;
    logic             res_ok_reg, res_ok_next;
    logic             res_taken_reg, res_taken_next;
    logic [15:0]      res_p25_reg, res_p25_next;
    logic [15:0]      res_p10_reg, res_p10_next;
    logic             res_avalid_reg, res_avalid_next;
    logic [AVG_W-1:0] res_a10_reg, res_a10_next;
    logic [AVG_W-1:0] res_a25_reg, res_a25_next;
    logic [1:0]       res_cmd_reg, res_cmd_next;

    // output register
    logic        m_tvalid_reg, m_tvalid_next;
    out_data_t   m_data_reg, m_data_next;
    out_user_t   m_user_reg, m_user_next;

    logic             parse_restart, parse_byte_en;
    frame_t           frame;
    logic             div_start, div_busy, div_done;
    logic [DIV_W-1:0] div_dividend;
    logic [AVG_W-1:0] div_quot;
    logic [31:0]      s_sel;
    logic             in_window;

    pmfa_frame_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (parse_restart),
        .byte_en (parse_byte_en),
        .byte_in (byte_reg),
        .frame   (frame)
    );

    pmfa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (n_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign in_window = !(long_iv_reg && (time_reg < win_start_reg));
    assign s_sel     = (state_reg == ST_START25) ? s25_reg : s10_reg;
    // times ten as x*8 + x*2
    assign div_dividend = {1'b0, s_sel, 3'b000} + {3'b000, s_sel, 1'b0};
    assign div_start    = (state_reg == ST_START10) || (state_reg == ST_START25);

    always_comb begin
        state_next      = state_reg;
        interval_next   = interval_reg;
        warmup_next     = warmup_reg;
        reading_next    = reading_reg;
        req_next        = req_reg;
        byte_next       = byte_reg;
        time_next       = time_reg;
        lead_next       = lead_reg;
        long_iv_next    = long_iv_reg;
        win_start_next  = win_start_reg;
        thr_next        = thr_reg;
        coarse_sum_next = coarse_sum_reg;
        fine_sum_next   = fine_sum_reg;
        coarse_min_next = coarse_min_reg;
        coarse_max_next = coarse_max_reg;
        fine_min_next   = fine_min_reg;
        fine_max_next   = fine_max_reg;
        count_next      = count_reg;
        error_next      = error_reg;
        running_next    = running_reg;
        s10_next        = s10_reg;
        s25_next        = s25_reg;
        n_next          = n_reg;
        res_done_next   = res_done_reg;
        res_ok_next     = res_ok_reg;
        res_taken_next  = res_taken_reg;
        res_p25_next    = res_p25_reg;
        res_p10_next    = res_p10_reg;
        res_avalid_next = res_avalid_reg;
        res_a10_next    = res_a10_reg;
        res_a25_next    = res_a25_reg;
        res_cmd_next    = res_cmd_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        parse_restart   = 1'b0;
        parse_byte_en   = 1'b0;

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_INTERVAL: interval_next = cfg_data;
                CFG_WARMUP:   warmup_next   = cfg_data[15:0];
                CFG_READING:  reading_next  = cfg_data[15:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_next   = s_tuser;
                    byte_next  = s_tdata[7:0];
                    time_next  = s_tdata[39:8];
                    state_next = ST_LEAD;
                end
            end
            ST_LEAD: begin
                lead_next  = {1'b0, warmup_reg} + {1'b0, reading_reg};
                state_next = ST_WIN;
            end
            ST_WIN: begin
                long_iv_next   = interval_reg > {15'd0, lead_reg};
                win_start_next = interval_reg - {15'd0, lead_reg};
                thr_next       = (interval_reg >= {16'd0, reading_reg}) ?
                                 interval_reg - {16'd0, reading_reg} : '0;
                state_next     = ST_EXEC;
            end
            ST_EXEC: begin
                res_done_next   = 1'b0;
                res_ok_next     = 1'b0;
                res_taken_next  = 1'b0;
                res_p25_next    = '0;
                res_p10_next    = '0;
                res_avalid_next = 1'b0;
                res_a10_next    = '0;
                res_a25_next    = '0;
                res_cmd_next    = CMD_NONE;
                state_next      = ST_OUT;
                if (req_reg == REQ_TICK || req_reg == REQ_BYTE) begin
                    if (!in_window) begin
                        if (running_reg) begin
                            running_next = 1'b0;
                            res_cmd_next = CMD_STOP;
                        end
                    end else begin
                        if (!running_reg) begin
                            running_next  = 1'b1;
                            res_cmd_next  = CMD_START;
                            parse_restart = 1'b1;
                        end
                        if (req_reg == REQ_BYTE) begin
                            parse_byte_en = 1'b1;
                            res_done_next = frame.done;
                            res_ok_next   = frame.ok;
                            res_p25_next  = frame.pm25;
                            res_p10_next  = frame.pm10;
                            if (frame.done && frame.ok && time_reg > thr_reg &&
                                count_reg != SAT_16) begin
                                res_taken_next  = 1'b1;
                                coarse_sum_next = coarse_sum_reg + {16'd0, frame.pm10};
                                fine_sum_next   = fine_sum_reg + {16'd0, frame.pm25};
                                if (frame.pm10 < coarse_min_reg) coarse_min_next = frame.pm10;
                                if (frame.pm10 > coarse_max_reg) coarse_max_next = frame.pm10;
                                if (frame.pm25 < fine_min_reg) fine_min_next = frame.pm25;
                                if (frame.pm25 > fine_max_reg) fine_max_next = frame.pm25;
                                count_next = count_reg + 16'd1;
                            end
                        end
                    end
                end else if (req_reg == REQ_COLLECT) begin
                    s10_next = coarse_sum_reg;
                    s25_next = fine_sum_reg;
                    n_next   = count_reg;
                    if (count_reg > 16'd2) begin
                        n_next     = count_reg - 16'd2;
                        state_next = ST_TRIM_MIN;
                    end else if (count_reg == 16'd0) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_START10;
                    end
                end
            end
            ST_TRIM_MIN: begin
                s10_next   = s10_reg - {16'd0, coarse_min_reg};
                s25_next   = s25_reg - {16'd0, fine_min_reg};
                state_next = ST_TRIM_MAX;
            end
            ST_TRIM_MAX: begin
                s10_next   = s10_reg - {16'd0, coarse_max_reg};
                s25_next   = s25_reg - {16'd0, fine_max_reg};
                state_next = ST_START10;
            end
            ST_START10: state_next = ST_DIV10;
            ST_DIV10: begin
                if (div_done) begin
                    res_a10_next = div_quot;
                    state_next   = ST_START25;
                end
            end
            ST_START25: state_next = ST_DIV25;
            ST_DIV25: begin
                if (div_done) begin
                    res_a25_next = div_quot;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH: begin
                res_avalid_next = (n_reg != 16'd0);
                // fewer than three samples counts as an error, none at all too
                if (count_reg < 16'd3 && error_reg != SAT_16) begin
                    error_next = error_reg + 16'd1;
                end
                coarse_sum_next = '0;
                fine_sum_next   = '0;
                coarse_min_next = MIN_RESET;
                fine_min_next   = MIN_RESET;
                coarse_max_next = '0;
                fine_max_next   = '0;
                count_next      = '0;
                if (long_iv_reg && running_reg) begin
                    running_next = 1'b0;
                    res_cmd_next = CMD_STOP;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next           = 1'b1;
                    m_data_next.pad         = '0;
                    m_data_next.cmd         = res_cmd_reg;
                    m_data_next.sensor_on   = running_reg;
                    m_data_next.error_total = error_reg;
                    m_data_next.avg25       = res_a25_reg;
                    m_data_next.avg10       = res_a10_reg;
                    m_data_next.pm10        = res_p10_reg;
                    m_data_next.pm25        = res_p25_reg;
                    m_user_next.avg_valid   = res_avalid_reg;
                    m_user_next.taken       = res_taken_reg;
                    m_user_next.ok          = res_ok_reg;
                    m_user_next.done        = res_done_reg;
                    state_next              = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            interval_reg   <= INTERVAL_RESET;
            warmup_reg     <= WARMUP_RESET;
            reading_reg    <= READING_RESET;
            coarse_sum_reg <= '0;
            fine_sum_reg   <= '0;
            coarse_min_reg <= MIN_RESET;
            coarse_max_reg <= '0;
            fine_min_reg   <= MIN_RESET;
            fine_max_reg   <= '0;
            count_reg      <= '0;
            error_reg      <= '0;
            running_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            interval_reg   <= interval_next;
            warmup_reg     <= warmup_next;
            reading_reg    <= reading_next;
            coarse_sum_reg <= coarse_sum_next;
            fine_sum_reg   <= fine_sum_next;
            coarse_min_reg <= coarse_min_next;
            coarse_max_reg <= coarse_max_next;
            fine_min_reg   <= fine_min_next;
            fine_max_reg   <= fine_max_next;
            count_reg      <= count_next;
            error_reg      <= error_next;
            running_reg    <= running_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        byte_reg       <= byte_next;
        time_reg       <= time_next;
        lead_reg       <= lead_next;
        long_iv_reg    <= long_iv_next;
        win_start_reg  <= win_start_next;
        thr_reg        <= thr_next;
        s10_reg        <= s10_next;
        s25_reg        <= s25_next;
        n_reg          <= n_next;
        res_done_reg   <= res_done_next;
        res_ok_reg     <= res_ok_next;
        res_taken_reg  <= res_taken_next;
        res_p25_reg    <= res_p25_next;
        res_p10_reg    <= res_p10_next;
        res_avalid_reg <= res_avalid_next;
        res_a10_reg    <= res_a10_next;
        res_a25_reg    <= res_a25_next;
        res_cmd_reg    <= res_cmd_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    a_div_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while still busy");

    a_no_mixed_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_user_reg.done && m_user_reg.avg_valid))
        else $error("frame and averages reported in one item");

    a_start_means_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_data_reg.cmd == CMD_START) |-> m_data_reg.sensor_on)
        else $error("start command reported with sensor off");

    a_error_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> error_reg >= $past(error_reg))
        else $error("error count went down");

    a_ready_not_dividing: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_busy)
        else $error("input ready during a division");

endmodule
